// ----- hw/rtl/led_matrix_scan_pwm_rotate_macros.svh -----
// Assertion macros shared by the LED matrix scanner RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef LED_MATRIX_SCAN_PWM_ROTATE_MACROS_SVH
`define LED_MATRIX_SCAN_PWM_ROTATE_MACROS_SVH

// checked only out of reset
`define LMSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define LMSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lmsr_pkg.sv -----
// Package for the LED matrix scanner: item types, codes, remap tables.
// No dependencies.
`timescale 1ns / 1ps

package lmsr_pkg;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] REG_ROTATION   = 2'd0;
  localparam logic [1:0] REG_AUTO_OFF   = 2'd1;
  localparam logic [1:0] REG_MIN_LEVEL  = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic [7:0] MAX_BRIGHTNESS = 8'd15;
  localparam logic [3:0] PWM_LAST       = 4'd8;
  localparam logic [3:0] COPY_ROW       = 4'd8;

  // source bit i goes to destination bit X[i]
  localparam logic [2:0] SWAP_DST   [8] = '{3'd7, 3'd5, 3'd4, 3'd6, 3'd0, 3'd3, 3'd1, 3'd2};
  localparam logic [2:0] MIRROR_DST [8] = '{3'd2, 3'd1, 3'd3, 3'd0, 3'd6, 3'd4, 3'd5, 3'd7};
  localparam logic [2:0] PERM_STD   [8] = '{3'd0, 3'd5, 3'd3, 3'd1, 3'd2, 3'd4, 3'd7, 3'd6};
  localparam logic [2:0] PERM_180   [8] = '{3'd7, 3'd2, 3'd4, 3'd6, 3'd5, 3'd3, 3'd0, 3'd1};

  typedef logic [7:0][7:0] row_arr_t;

  typedef struct packed {
    logic       op;
    logic [2:0] row_index;
    logic [7:0] row_data;
    logic [7:0] light;
  } in_item_t;

  typedef struct packed {
    logic [7:0] row_enable;
    logic [7:0] column_data;
  } out_item_t;

  typedef struct packed {
    logic [1:0] rotation;
    logic       auto_brightness_off;
    logic [2:0] min_level;
  } cfg_t;

  function automatic logic [7:0] remap_bits(input logic [7:0] v, input logic mirror);
    logic [7:0] o;
    o = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        o[mirror ? MIRROR_DST[i] : SWAP_DST[i]] = 1'b1;
      end
    end
    return o;
  endfunction

endpackage

// ----- hw/rtl/lmsr_copy.sv -----
// Frame-to-display copy network: rotation, row permutation, bit swap or mirror.
// Depends on lmsr_pkg.
`timescale 1ns / 1ps

module lmsr_copy (
  input  lmsr_pkg::row_arr_t frame_i,
  input  logic [1:0]         rotation_i,
  output lmsr_pkg::row_arr_t display_o
);
  import lmsr_pkg::*;

  row_arr_t   turned;
  row_arr_t   src;
  logic       mirror;
  logic       quarter;

  assign quarter = (rotation_i == ROT_90) || (rotation_i == ROT_270);
  assign mirror  = (rotation_i == ROT_90) || (rotation_i == ROT_180);

  // transpose; 90 deg reads source bit r, 270 deg reads bit 7-r
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        turned[r][c] = frame_i[c][(rotation_i == ROT_90) ? 3'(r) : 3'(7 - r)];
      end
    end
  end

  assign src = quarter ? turned : frame_i;

  always_comb begin
    for (int r = 0; r < 8; r++) begin
      display_o[r] = remap_bits(src[(rotation_i == ROT_180) ? PERM_180[r] : PERM_STD[r]],
                                mirror);
    end
  end

endmodule

// ----- hw/rtl/lmsr_scan.sv -----
// Scan state: frame and display stores, row/pwm counters, brightness.
// Depends on lmsr_pkg and lmsr_copy.
`timescale 1ns / 1ps

module lmsr_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lmsr_pkg::in_item_t  item_i,
  input  lmsr_pkg::cfg_t      cfg_i,
  output lmsr_pkg::out_item_t res_o
);
  import lmsr_pkg::*;

  row_arr_t   frame_q, frame_d;
  row_arr_t   disp_q, disp_d;
  row_arr_t   disp_next;
  logic [3:0] scan_row_q, scan_row_d;
  logic [3:0] pwm_q, pwm_d;
  logic [7:0] bright_q, bright_d;
  logic       copy_tick;
  logic [4:0] floor_v;
  logic [7:0] light_b;
  logic [7:0] b_raw;
  logic [7:0] b_new;

  lmsr_copy u_copy (
    .frame_i    (frame_q),
    .rotation_i (cfg_i.rotation),
    .display_o  (disp_next)
  );

  assign copy_tick = scan_row_q >= COPY_ROW;

  // wraps: 1 - light/16 in 8 bits
  assign floor_v = 5'({2'b00, cfg_i.min_level} * 5'd3);
  assign light_b = 8'd1 - {4'b0000, item_i.light[7:4]};
  assign b_raw   = cfg_i.auto_brightness_off ? MAX_BRIGHTNESS : light_b;
  assign b_new   = (b_raw < {3'b000, floor_v}) ? {3'b000, floor_v} : b_raw;

  always_comb begin
    frame_d    = frame_q;
    disp_d     = disp_q;
    scan_row_d = scan_row_q;
    pwm_d      = pwm_q;
    bright_d   = bright_q;
    if (step_i) begin
      if (item_i.op == OP_WRITE) begin
        frame_d[item_i.row_index] = item_i.row_data;
      end else if (copy_tick) begin
        disp_d     = disp_next;
        bright_d   = b_new;
        scan_row_d = '0;
        pwm_d      = '0;
      end else if (pwm_q >= PWM_LAST) begin
        pwm_d      = '0;
        scan_row_d = scan_row_q + 4'd1;
      end else begin
        pwm_d = pwm_q + 4'd1;
      end
    end
  end

  always_comb begin
    if (copy_tick) begin
      res_o = '0;
    end else begin
      res_o.row_enable  = 8'd1 << scan_row_q[2:0];
      res_o.column_data = (pwm_q < bright_q[3:0]) ? disp_q[scan_row_q[2:0]] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q    <= '0;
      disp_q     <= '0;
      scan_row_q <= '0;
      pwm_q      <= '0;
      bright_q   <= MAX_BRIGHTNESS;
    end else begin
      frame_q    <= frame_d;
      disp_q     <= disp_d;
      scan_row_q <= scan_row_d;
      pwm_q      <= pwm_d;
      bright_q   <= bright_d;
    end
  end

endmodule

// ----- hw/rtl/led_matrix_scan_pwm_rotate.sv -----
// 8x8 LED matrix row scanner with PWM gating and rotate-on-copy. One item
// can be taken every clock cycle unless the input is stalled: an accepted item
// sits in an input register until it advances, is applied to the scan state
// by a single combinational pass, and a tick's row/column result lands in the
// output register as the tick leaves the input register. Row writes give no
// result. Throughput is set by that single update pass; the input side stalls
// only while a tick waits behind a held output. The frame, display and config
// stores are flip-flops cleared by reset; no start-up sweep.
// Depends on lmsr_pkg, lmsr_scan, lmsr_copy and the assertion macro header.
`timescale 1ns / 1ps

module led_matrix_scan_pwm_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lmsr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lmsr_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [2:0]          cfg_data_i
);
  import lmsr_pkg::*;
  `include "led_matrix_scan_pwm_rotate_macros.svh"

  cfg_t      cfg_q, cfg_d;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  out_item_t res;
  logic      out_free;
  logic      advance;
  logic      emit;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ROTATION:  cfg_d.rotation            = cfg_data_i[1:0];
        REG_AUTO_OFF:  cfg_d.auto_brightness_off = cfg_data_i[0];
        REG_MIN_LEVEL: cfg_d.min_level           = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && ((s1_q.op == OP_WRITE) || out_free);
  assign emit       = advance && (s1_q.op == OP_TICK);
  assign in_stall_o = s1_valid_q && !advance;
  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  lmsr_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (s1_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= in_data_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LMSR_ASSERT(a_stall_needs_item, in_stall_o |-> s1_valid_q, "input stalled with empty stage")
  `LMSR_ASSERT(a_tick_emits, emit |=> out_valid_q, "tick transfer produced no result")
  `LMSR_ASSERT(a_dark_on_copy, (out_valid_q && out_q.row_enable == 8'd0) |-> (out_q.column_data == 8'd0), "columns driven with no row")
  `LMSR_ASSERT(a_row_onehot, out_valid_q |-> $onehot0(out_q.row_enable), "more than one row enabled")
  `LMSR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> (!out_valid_q && !s1_valid_q), "pipeline not empty in reset")

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for led_matrix_scan_pwm_rotate: row loads and scan ticks
// go in, row/column results are checked against an in-bench scan model.
// Depends on lmsr_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb_top;
  import lmsr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned FRAME_TICKS    = 73;  // 8 rows x 9 slots + copy tick
  localparam int unsigned PHASE_ITEMS    = 90;
  localparam logic [7:0]  FULL_LEVEL     = 8'd15;
  localparam logic [3:0]  PWM_TOP        = 4'd8;
  localparam logic [3:0]  COPY_SLOT      = 4'd8;

  // bit scatter maps (entry i = destination of source bit i) and row orders
  localparam logic [7:0][2:0] SWAP_TO   = {3'd2, 3'd1, 3'd3, 3'd0, 3'd6, 3'd4, 3'd5, 3'd7};
  localparam logic [7:0][2:0] MIRROR_TO = {3'd7, 3'd5, 3'd4, 3'd6, 3'd0, 3'd3, 3'd1, 3'd2};
  localparam logic [7:0][2:0] ROWS_STD  = {3'd6, 3'd7, 3'd4, 3'd2, 3'd1, 3'd3, 3'd5, 3'd0};
  localparam logic [7:0][2:0] ROWS_180  = {3'd1, 3'd0, 3'd3, 3'd5, 3'd6, 3'd4, 3'd2, 3'd7};

  typedef enum logic [1:0] {
    PACE_FULL,
    PACE_SRC_IDLE,
    PACE_SNK_STALL,
    PACE_BOTH
  } pace_e;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [2:0] cfg_data_i  = '0;

  led_matrix_scan_pwm_rotate i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // scan model state and its register copy
  logic [7:0] frame_rows [8];
  logic [7:0] shown_rows [8];
  logic [3:0] scan_row_m;
  logic [3:0] pwm_m;
  logic [7:0] level_m;
  logic [1:0] rot_cfg;
  logic       auto_off_cfg;
  logic [2:0] min_lvl_cfg;

  in_item_t    items_to_send [$];
  out_item_t   expected_scan_q [$];
  out_item_t   want;
  pace_e       pace = PACE_FULL;
  logic        hold_kick = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fails = 0;
  int unsigned ticks_queued = 0;
  int unsigned copies_queued = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // frame -> display copy with rotation, row order and bit scatter
  task automatic latch_display();
    logic [7:0] turned [8];
    logic [7:0] src;
    logic [2:0] sel;
    logic       mirror;
    for (int r = 0; r < 8; r++) begin
      if (rot_cfg == ROT_90 || rot_cfg == ROT_270) begin
        sel = (rot_cfg == ROT_90) ? 3'(r) : 3'(7 - r);
        for (int c = 0; c < 8; c++) turned[r][c] = frame_rows[c][sel];
      end else begin
        turned[r] = frame_rows[r];
      end
    end
    mirror = (rot_cfg == ROT_90) || (rot_cfg == ROT_180);
    for (int r = 0; r < 8; r++) begin
      src = turned[(rot_cfg == ROT_180) ? ROWS_180[r] : ROWS_STD[r]];
      shown_rows[r] = '0;
      for (int b = 0; b < 8; b++) begin
        if (src[b]) shown_rows[r][mirror ? MIRROR_TO[b] : SWAP_TO[b]] = 1'b1;
      end
    end
  endtask

  task automatic advance_scan(input in_item_t it);
    out_item_t  res;
    logic [7:0] floor_v;
    if (it.op == OP_WRITE) begin
      frame_rows[it.row_index] = it.row_data;
      return;
    end
    if (scan_row_m >= COPY_SLOT) begin
      latch_display();
      floor_v = 8'(min_lvl_cfg) * 8'd3;
      level_m = auto_off_cfg ? FULL_LEVEL : 8'd1 - {4'd0, it.light[7:4]};
      if (level_m < floor_v) level_m = floor_v;
      scan_row_m = '0;
      pwm_m = '0;
      res = '0;
    end else begin
      res.row_enable  = 8'd1 << scan_row_m[2:0];
      res.column_data = (pwm_m < level_m[3:0]) ? shown_rows[scan_row_m[2:0]] : 8'd0;
      if (pwm_m >= PWM_TOP) begin
        pwm_m = '0;
        scan_row_m = scan_row_m + 4'd1;
      end else begin
        pwm_m = pwm_m + 4'd1;
      end
    end
    expected_scan_q.push_back(res);
  endtask

  function automatic logic src_idles();
    case (pace)
      PACE_SRC_IDLE: return $urandom_range(99) < 82;
      PACE_BOTH:     return $urandom_range(99) < 24;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic snk_stalls();
    case (pace)
      PACE_SNK_STALL: return $urandom_range(99) < 82;
      PACE_BOTH:      return $urandom_range(99) < 24;
      default:        return 1'b0;
    endcase
  endfunction

  // sender: payload holds while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        advance_scan(in_data_i);
        items_to_send.delete(0);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (items_to_send.size() != 0 && !src_idles()) begin
          in_valid_i <= 1'b1;
          in_data_i  <= items_to_send[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver, with an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_kick) begin
      hold_left = HOLD_CYCLES;
      hold_kick = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= snk_stalls();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scan_q.size() == 0) begin
        $error("unexpected result row_enable=%h column_data=%h",
               out_data_o.row_enable, out_data_o.column_data);
        fails++;
      end else begin
        want = expected_scan_q.pop_front();
        if (out_data_o.row_enable !== want.row_enable) begin
          $error("row_enable: expected %h, got %h", want.row_enable, out_data_o.row_enable);
          fails++;
        end
        if (out_data_o.column_data !== want.column_data) begin
          $error("column_data: expected %h, got %h", want.column_data, out_data_o.column_data);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic program_regs(input logic [1:0] rot, input logic off, input logic [2:0] lvl);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_ROTATION;
    cfg_data_i  <= {1'b0, rot};
    @(posedge clk_i);
    cfg_index_i <= REG_AUTO_OFF;
    cfg_data_i  <= {2'b00, off};
    @(posedge clk_i);
    cfg_index_i <= REG_MIN_LEVEL;
    cfg_data_i  <= lvl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rot_cfg      = rot;
    auto_off_cfg = off;
    min_lvl_cfg  = lvl;
  endtask

  task automatic queue_item(input logic op, input logic [2:0] idx, input logic [7:0] data,
                            input logic [7:0] light);
    in_item_t it;
    it.op        = op;
    it.row_index = idx;
    it.row_data  = data;
    it.light     = light;
    items_to_send.push_back(it);
    if (op == OP_TICK) ticks_queued++;
  endtask

  function automatic logic [7:0] pick_pixels();
    if ($urandom_range(4) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // frame load up front, then ticks with stray row writes; the light on the
  // copy tick walks through the brightness corners
  task automatic queue_frames(input int unsigned count);
    logic [7:0] lt;
    for (int unsigned k = 0; k < count; k++) begin
      if (k < 8) begin
        queue_item(OP_WRITE, 3'(k), pick_pixels(), 8'($urandom));
      end else if ($urandom_range(9) == 0) begin
        queue_item(OP_WRITE, 3'($urandom_range(7)), pick_pixels(), 8'($urandom));
      end else begin
        if (ticks_queued % FRAME_TICKS == FRAME_TICKS - 1) begin
          case (copies_queued % 7)
            0:       lt = 8'd0;
            1:       lt = 8'd15;
            2:       lt = 8'd16;
            3:       lt = 8'd31;
            4:       lt = 8'd32;
            5:       lt = 8'd255;
            default: lt = 8'($urandom);
          endcase
          copies_queued++;
        end else begin
          lt = 8'($urandom);
        end
        queue_item(OP_TICK, 3'($urandom), 8'($urandom), lt);
      end
    end
  endtask

  // writes give no result, so allow for a trailing one still in flight
  task automatic wait_drain();
    while (items_to_send.size() != 0 || expected_scan_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [1:0] rot, input logic off, input logic [2:0] lvl,
                           input pace_e p, input logic hold);
    program_regs(rot, off, lvl);
    pace = p;
    if (hold) hold_kick = 1'b1;
    queue_frames(PHASE_ITEMS);
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      frame_rows[i] = '0;
      shown_rows[i] = '0;
    end
    scan_row_m   = '0;
    pwm_m        = '0;
    level_m      = FULL_LEVEL;
    rot_cfg      = ROT_0;
    auto_off_cfg = 1'b0;
    min_lvl_cfg  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner pixel patterns, ignored fields at both extremes
    program_regs(ROT_0, 1'b0, 3'd0);
    queue_item(OP_WRITE, 3'd0, 8'hFF, 8'h00);
    queue_item(OP_WRITE, 3'd7, 8'h00, 8'hFF);
    queue_item(OP_WRITE, 3'd1, 8'h80, 8'h00);
    queue_item(OP_WRITE, 3'd2, 8'h04, 8'hFF);
    queue_item(OP_WRITE, 3'd3, 8'h01, 8'h00);
    queue_item(OP_WRITE, 3'd4, 8'hAA, 8'hFF);
    queue_item(OP_WRITE, 3'd5, 8'h55, 8'h00);
    queue_item(OP_WRITE, 3'd6, 8'hFF, 8'hFF);
    for (int j = 0; j < 14; j++) begin
      queue_item(OP_TICK, (j % 2) ? 3'd7 : 3'd0, (j % 2) ? 8'hFF : 8'h00,
                 ((j / 2) % 2) ? 8'hFF : 8'h00);
    end
    wait_drain();

    run_phase(ROT_0,   1'b0, 3'd0, PACE_FULL,      1'b1);
    run_phase(ROT_90,  1'b0, 3'd5, PACE_SRC_IDLE,  1'b0);
    run_phase(ROT_180, 1'b1, 3'd0, PACE_SNK_STALL, 1'b0);
    run_phase(ROT_270, 1'b0, 3'd7, PACE_BOTH,      1'b0);
    run_phase(ROT_90,  1'b1, 3'd6, PACE_FULL,      1'b0);
    run_phase(ROT_180, 1'b0, 3'd3, PACE_SRC_IDLE,  1'b0);
    run_phase(ROT_270, 1'b1, 3'd5, PACE_SNK_STALL, 1'b0);
    run_phase(ROT_0,   1'b0, 3'd6, PACE_BOTH,      1'b0);

    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
